// ===== rtl/spf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg - stepper position follower shared definitions
// Direction codes, register indexes, reset constants, the half-step coil
// table and the divide-by-ten used to refill the ramp wait.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int POS_BITS_DEF = 16;   // default position register width
    localparam int TGT_W        = 16;   // target / reported position width
    localparam int RAMP_W       = 7;    // ramp level and wait width
    localparam int STBY_W       = 16;   // standby counter width
    localparam int PHASE_W      = 3;    // half-step phase width
    localparam int COIL_W       = 4;    // one bit per coil
    localparam int CFG_DATA_W   = 16;   // widest register
    localparam int IN_TDATA_W   = 24;   // 17 payload bits padded to bytes
    localparam int OUT_TDATA_W  = 24;   // 22 payload bits padded to bytes

    localparam logic [STBY_W-1:0] STANDBY_RESET = STBY_W'(500);

    // level / 10 for a 7-bit level: (x * 205) >> 11 is exact below 1029
    localparam int RAMP_DIV   = 10;
    localparam int DIV_SHIFT  = 11;
    localparam int DIV_MUL    = ((1 << DIV_SHIFT) + RAMP_DIV - 1) / RAMP_DIV;
    localparam int DIV_PROD_W = DIV_SHIFT + RAMP_W;

    typedef enum logic [1:0] {
        DIR_DOWN = 2'd0,
        DIR_UP   = 2'd1,
        DIR_STOP = 2'd2
    } t_dir;

    typedef enum logic [0:0] {
        CFG_ACCEL_START   = 1'b0,
        CFG_STANDBY_TICKS = 1'b1
    } t_cfg_idx;

    // coil bit positions
    localparam int COIL_A = 0;
    localparam int COIL_B = 1;
    localparam int COIL_C = 2;
    localparam int COIL_D = 3;

    function automatic logic [RAMP_W-1:0] f_div10(input logic [RAMP_W-1:0] x);
        logic [DIV_PROD_W-1:0] prod;
        prod = DIV_PROD_W'(x) * DIV_PROD_W'(DIV_MUL);
        return prod[DIV_SHIFT +: RAMP_W];
    endfunction

    // Half-step sequence: each phase sets or clears a single coil.
    function automatic logic [COIL_W-1:0] f_coil_step(
        input logic [PHASE_W-1:0] phase,
        input logic [COIL_W-1:0]  coils
    );
        logic [COIL_W-1:0] c;
        c = coils;
        case (phase)
            3'd0:    c[COIL_C] = 1'b1;
            3'd1:    c[COIL_D] = 1'b0;
            3'd2:    c[COIL_B] = 1'b1;
            3'd3:    c[COIL_C] = 1'b0;
            3'd4:    c[COIL_A] = 1'b1;
            3'd5:    c[COIL_B] = 1'b0;
            3'd6:    c[COIL_D] = 1'b1;
            default: c[COIL_A] = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/stepper_position_follower.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_position_follower - half-step unipolar stepper axis with ramp
// Moves the axis one half step per tick at most toward the requested target,
// with a start ramp after each direction change and coil standby at target.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                | contents
//  ----------+-----+--------------------------+-----------------------------
//  s_axis    | in  | tvalid/tready            | one tick request
//  m_axis    | out | tvalid/tready            | one result per request
//  cfg       | in  | i_cfg_we (no handshake)  | accel_start, standby_ticks
//
//  Flow: one request per clock while results are taken; a request is first
//  held in the input register, the tick is evaluated there and its result
//  then lands in the output register, from which the receiver takes it.
//  Reset (synchronous, i_rst_n low): axis state, registers and both stage
//  valids clear; accel_start = 0, standby_ticks = 500.
//  Stalls: a stalled output holds its result while the input register still
//  takes one more request; tready drops only when both stages are full.
//  Config writes are expected only while no request is in flight.
//
module stepper_position_follower #(
    parameter int POS_BITS = spf_pkg::POS_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request: [15:0] target_position, [16] axis_enable, [23:17] zero
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [spf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // result: [3:0] coil_drive, [19:4] position, [20] stepped,
    //         [21] at_target, [23:22] zero
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [spf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration write port
    input  logic                               i_cfg_we,
    input  spf_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [spf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import spf_pkg::*;

    // compare width: wide enough for the position and the 16-bit target
    localparam int CMP_W = (POS_BITS > TGT_W) ? POS_BITS : TGT_W;

    // configuration
    logic [RAMP_W-1:0]   r_accel_start;
    logic [STBY_W-1:0]   r_standby_ticks;

    // input stage
    logic                r_in_valid;
    logic [TGT_W-1:0]    r_in_tgt;
    logic                r_in_en;

    // output stage
    logic                r_out_valid;
    logic [COIL_W-1:0]   r_out_coil;
    logic [TGT_W-1:0]    r_out_pos;
    logic                r_out_stepped;
    logic                r_out_at_target;

    // axis state
    logic [POS_BITS-1:0] r_pos,     n_pos;
    logic [PHASE_W-1:0]  r_phase,   n_phase;
    t_dir                r_dir,     n_dir;
    logic [RAMP_W-1:0]   r_lvl,     n_lvl;
    logic [RAMP_W-1:0]   r_wait,    n_wait;
    logic [STBY_W-1:0]   r_standby, n_standby;
    logic [COIL_W-1:0]   r_coil,    n_coil;

    logic                w_adv;     // input stage moves into output stage
    logic                w_step;
    logic                w_at;
    t_dir                w_want;
    logic signed [CMP_W-1:0] w_pos_x;
    logic signed [CMP_W-1:0] w_tgt_x;
    logic [31:0]         w_pos_z;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    // position is sign-extended for the compare, reported zero-extended
    assign w_pos_x = CMP_W'(signed'(r_pos));
    assign w_tgt_x = CMP_W'(signed'(r_in_tgt));
    assign w_pos_z = 32'(r_pos);

    // ---------------------------------------------------------------------
    // tick evaluation on the registered request
    // ---------------------------------------------------------------------
    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_dir     = r_dir;
        n_lvl     = r_lvl;
        n_wait    = r_wait;
        n_standby = r_standby;
        n_coil    = r_coil;
        w_step    = 1'b0;
        w_at      = 1'b0;
        w_want    = (w_pos_x > w_tgt_x) ? DIR_DOWN : DIR_UP;

        if (r_in_en) begin
            if (w_pos_x != w_tgt_x) begin
                n_standby = r_standby_ticks;
                // direction change restarts the ramp
                if (r_dir != w_want) begin
                    n_lvl = r_accel_start;
                    n_wait = r_accel_start;
                    n_dir = w_want;
                end
                if (n_lvl != '0) begin
                    if (n_wait != '0) begin
                        n_wait = n_wait - RAMP_W'(1);
                    end else begin
                        n_lvl = n_lvl - RAMP_W'(1);
                        n_wait = f_div10(n_lvl);
                        w_step = 1'b1;
                    end
                end else begin
                    w_step = 1'b1;
                end
                if (w_step) begin
                    n_coil = f_coil_step(r_phase, r_coil);
                    if (w_want == DIR_UP) begin
                        n_phase = r_phase + PHASE_W'(1);
                        n_pos = r_pos + POS_BITS'(1);
                    end else begin
                        n_phase = r_phase - PHASE_W'(1);
                        n_pos = r_pos - POS_BITS'(1);
                    end
                end
            end else begin
                // at target: count down standby, then release the coils
                w_at = 1'b1;
                n_dir = DIR_STOP;
                if (r_standby != '0) begin
                    n_standby = r_standby - STBY_W'(1);
                end
                if (n_standby == '0) begin
                    n_coil = '0;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_start   <= '0;
            r_standby_ticks <= STANDBY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEL_START:   r_accel_start   <= i_cfg_wdata[RAMP_W-1:0];
                CFG_STANDBY_TICKS: r_standby_ticks <= i_cfg_wdata[STBY_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_tgt <= i_s_axis_tdata[TGT_W-1:0];
            r_in_en  <= i_s_axis_tdata[TGT_W];
        end
    end

    // axis state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_dir       <= DIR_DOWN;
            r_lvl       <= '0;
            r_wait      <= '0;
            r_standby   <= '0;
            r_coil      <= '0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_pos     <= n_pos;
                r_phase   <= n_phase;
                r_dir     <= n_dir;
                r_lvl     <= n_lvl;
                r_wait    <= n_wait;
                r_standby <= n_standby;
                r_coil    <= n_coil;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out_coil      <= n_coil;
            r_out_pos       <= 16'(32'(n_pos));
            r_out_stepped   <= w_step;
            r_out_at_target <= w_at;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_at_target, r_out_stepped, r_out_pos, r_out_coil};

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_step_xor_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_stepped && r_out_at_target))
        else $error("step and at-target in one result");

    a_stop_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_at_target) |-> (r_dir == DIR_STOP))
        else $error("direction not stopped at target");

    a_standby_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_at_target && r_standby == '0) |-> (r_out_coil == '0))
        else $error("coils still driven after standby expired");

    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_valid && w_step) |=> (r_pos != $past(r_pos)))
        else $error("step without position change");

    a_report_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pos == w_pos_z[TGT_W-1:0]))
        else $error("reported position differs from state");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("request blocked with a free stage");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stepper position follower testbench
// Sends tick requests over the input stream and checks every result on the
// output stream against an in-bench prediction of the axis (position, phase,
// direction, start ramp, standby timer, coils). Covers directed moves,
// reversals, the ramp at several start levels, coil standby, a long output
// stall and random well-formed target sequences with noise.
// ----------------------------------------------------------------------------
module tb;
    import spf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request or result
    localparam int HOLD_CYCLES    = 80;    // long receiver stall
    localparam int IDLE_PCT       = 29;

    // result fields, lowest bit last so the struct matches tdata[21:0]
    typedef struct packed {
        logic              at_tgt;
        logic              stepped;
        logic [TGT_W-1:0]  pos;
        logic [COIL_W-1:0] coils;
    } tick_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // [15:0] target, [16] enable
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // [3:0] coils, [19:4] pos,
                                              // [20] stepped, [21] at_target
    logic                   i_cfg_we;
    t_cfg_idx               i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    stepper_position_follower u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Axis prediction: registers and state as seen after every accepted
    // request
    // ------------------------------------------------------------------
    logic [RAMP_W-1:0]        cfg_accel;
    logic [STBY_W-1:0]        cfg_standby;
    logic signed [TGT_W-1:0]  ax_pos;
    logic [PHASE_W-1:0]       ax_phase;
    t_dir                     ax_dir;
    logic [RAMP_W-1:0]        ax_level;
    logic [RAMP_W-1:0]        ax_wait;
    logic [STBY_W-1:0]        ax_standby;
    logic [COIL_W-1:0]        ax_coils;

    tick_result_t tick_q[$];   // predicted results, oldest first
    int unsigned  errors;
    bit           sender_gaps;
    bit           receiver_gaps;
    int unsigned  holds_asked;
    int unsigned  holds_served;
    int unsigned  idle_cycles = 0;

    function automatic tick_result_t axis_tick(input logic [TGT_W-1:0] tgt_bits,
                                               input logic en);
        tick_result_t            r;
        logic signed [TGT_W-1:0] tgt;
        t_dir                    want;
        logic                    moved;
        logic                    at;
        tgt   = $signed(tgt_bits);
        moved = 1'b0;
        at    = 1'b0;
        if (en) begin
            if (ax_pos != tgt) begin
                if (ax_pos > tgt)
                    want = DIR_DOWN;
                else
                    want = DIR_UP;
                ax_standby = cfg_standby;
                // any new heading (stopped included) restarts the ramp
                if (ax_dir != want) begin
                    ax_level = cfg_accel;
                    ax_wait  = cfg_accel;
                    ax_dir   = want;
                end
                if (ax_level != 0 && ax_wait != 0) begin
                    ax_wait = ax_wait - 1'b1;
                end else begin
                    if (ax_level != 0) begin
                        ax_level = ax_level - 1'b1;
                        ax_wait  = RAMP_W'(ax_level / RAMP_DIV);
                    end
                    // half-step table: one coil set or cleared per phase
                    case (ax_phase)
                        3'd0:    ax_coils[COIL_C] = 1'b1;
                        3'd1:    ax_coils[COIL_D] = 1'b0;
                        3'd2:    ax_coils[COIL_B] = 1'b1;
                        3'd3:    ax_coils[COIL_C] = 1'b0;
                        3'd4:    ax_coils[COIL_A] = 1'b1;
                        3'd5:    ax_coils[COIL_B] = 1'b0;
                        3'd6:    ax_coils[COIL_D] = 1'b1;
                        default: ax_coils[COIL_A] = 1'b0;
                    endcase
                    if (ax_dir != DIR_DOWN) begin
                        ax_phase = ax_phase + 1'b1;
                        ax_pos   = ax_pos + 1'b1;
                    end else begin
                        ax_phase = ax_phase - 1'b1;
                        ax_pos   = ax_pos - 1'b1;
                    end
                    moved = 1'b1;
                end
            end else begin
                at     = 1'b1;
                ax_dir = DIR_STOP;
                if (ax_standby != 0)
                    ax_standby = ax_standby - 1'b1;
                if (ax_standby == 0)
                    ax_coils = '0;   // phase is kept
            end
        end
        r.coils   = ax_coils;
        r.pos     = ax_pos;
        r.stepped = moved;
        r.at_tgt  = at;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Request driver, config writes, drain
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [TGT_W-1:0] tgt, input logic en);
        @(negedge i_clk);
        while (sender_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - TGT_W - 1){1'b0}}, en, tgt};
        do @(posedge i_clk); while (!o_s_axis_tready);
        tick_q.push_back(axis_tick(tgt, en));
    endtask

    // drop tvalid, then wait until every predicted result has been seen
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (tick_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_ACCEL_START)
            cfg_accel = val[RAMP_W-1:0];
        else
            cfg_standby = val;
    endtask

    // same target for n ticks, enabled
    task automatic hold_target(input logic [TGT_W-1:0] tgt, input int n);
        repeat (n) send_tick(tgt, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset values: no ramp, 500-tick standby
    task automatic test_directed_ticks();
        send_tick(16'd5, 1'b0);          // disabled: nothing moves
        send_tick(16'd0, 1'b1);          // already there
        hold_target(16'd3, 4);           // up three, then at target
        send_tick(16'hFFFE, 1'b0);       // disabled mid-sequence
        hold_target(16'hFFFE, 6);        // reverse down to -2
        send_tick(16'h7FFF, 1'b1);       // most positive target
        send_tick(16'h8000, 1'b1);       // most negative, reverses
        send_tick(16'h8000, 1'b1);
        send_tick(16'h8000, 1'b0);
        hold_target(16'hFFFF, 3);        // back up to -1, arrive
        send_tick(16'hFFFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_accel_ramp();
        // longest ramp: 127 ticks of waiting before the first step
        cfg_write(CFG_ACCEL_START, 16'd127);
        hold_target(ax_pos + 16'd4, 135);
        // start level just over ten: wait refill crosses level/10 boundary
        cfg_write(CFG_ACCEL_START, 16'd11);
        hold_target(ax_pos - 16'd6, 22);
        cfg_write(CFG_ACCEL_START, 16'd1);
        hold_target(ax_pos + 16'd3, 6);
        // reversal in the middle of a ramp reloads it
        cfg_write(CFG_ACCEL_START, 16'd5);
        hold_target(ax_pos + 16'd5, 4);
        hold_target(ax_pos - 16'd3, 12);
        cfg_write(CFG_ACCEL_START, 16'd0);
        wait_drained();
    endtask

    task automatic test_standby_release();
        // zero standby: coils drop on the first tick at target
        cfg_write(CFG_STANDBY_TICKS, 16'd0);
        hold_target(ax_pos + 16'd2, 4);
        cfg_write(CFG_STANDBY_TICKS, 16'd3);
        hold_target(ax_pos - 16'd2, 7);
        send_tick(ax_pos + 16'd1, 1'b1); // move again after coils went off
        hold_target(ax_pos, 2);
        cfg_write(CFG_STANDBY_TICKS, 16'hFFFF);
        hold_target(ax_pos + 16'd2, 5);
        cfg_write(CFG_STANDBY_TICKS, 16'd1);
        hold_target(ax_pos - 16'd1, 3);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        holds_asked++;                   // receiver stalls, pipeline fills
        hold_target(ax_pos + 16'd10, 30);
        wait_drained();                  // sender pauses until all results in
        sender_gaps = 1'b1;
        hold_target(ax_pos - 16'd5, 20);
        wait_drained();
    endtask

    task automatic test_random_ticks();
        logic [TGT_W-1:0] goal;
        logic [TGT_W-1:0] tgt;
        logic             en;
        int               hold_left;
        hold_left = 0;
        goal      = ax_pos;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       cfg_write(CFG_ACCEL_START, 16'd0);
                3:       cfg_write(CFG_ACCEL_START, 16'd127);
                default: cfg_write(CFG_ACCEL_START, 16'($urandom_range(0, 12)));
            endcase
            case (ph)
                2:       cfg_write(CFG_STANDBY_TICKS, 16'hFFFF);
                5:       cfg_write(CFG_STANDBY_TICKS, 16'd0);
                default: cfg_write(CFG_STANDBY_TICKS, 16'($urandom_range(0, 6)));
            endcase
            // first phase runs flat out on both sides
            sender_gaps   = (ph != 0);
            receiver_gaps = (ph != 0);
            repeat (30) begin
                if (hold_left == 0) begin
                    if ($urandom_range(0, 99) < 8) begin
                        goal      = 16'($urandom);
                        hold_left = $urandom_range(1, 3);
                    end else begin
                        goal      = ax_pos + 16'($urandom_range(0, 24)) - 16'd12;
                        hold_left = $urandom_range(1, 25);
                    end
                end
                hold_left--;
                tgt = goal;
                en  = ($urandom_range(0, 99) < 90);
                if ($urandom_range(0, 99) < 4)
                    tgt = 16'($urandom);     // one-off stray target
                send_tick(tgt, en);
            end
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random idling, plus long stalls on request
    // ------------------------------------------------------------------
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= !(receiver_gaps && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        tick_result_t got;
        tick_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = tick_result_t'(o_m_axis_tdata[$bits(tick_result_t)-1:0]);
            if (tick_q.size() == 0) begin
                report_mismatch("result with nothing expected", got, 0);
            end else begin
                want = tick_q.pop_front();
                if (got.coils !== want.coils)
                    report_mismatch("coil_drive", got.coils, want.coils);
                if (got.pos !== want.pos)
                    report_mismatch("position", got.pos, want.pos);
                if (got.stepped !== want.stepped)
                    report_mismatch("stepped", got.stepped, want.stepped);
                if (got.at_tgt !== want.at_tgt)
                    report_mismatch("at_target", got.at_tgt, want.at_tgt);
            end
        end
    end

    // watchdog: too long with no request and no result moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_ACCEL_START;
        i_cfg_wdata     = '0;
        errors          = 0;
        holds_asked     = 0;
        holds_served    = 0;
        sender_gaps     = 1'b1;
        receiver_gaps   = 1'b1;
        cfg_accel       = '0;
        cfg_standby     = STANDBY_RESET;
        ax_pos          = '0;
        ax_phase        = '0;
        ax_dir          = DIR_DOWN;
        ax_level        = '0;
        ax_wait         = '0;
        ax_standby      = '0;
        ax_coils        = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ticks();
        test_accel_ramp();
        test_standby_release();
        test_output_backpressure();
        test_random_ticks();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (tick_q.size() != 0)
            report_mismatch("results never arrived", tick_q.size(), 0);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
